// File: src/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg: shared types and constants for distinct_prime_factors
// Sequencer states, first trial candidates and the run length limit.
// ----------------------------------------------------------------------------
package dpf_pkg;

    localparam int COUNT_WIDTH = 4;
    localparam logic [COUNT_WIDTH-1:0] RUN_LIMIT = 4'd9;

    localparam int CAND_FIRST  = 2;
    localparam int CAND_SECOND = 3;
    localparam int CAND_STEP   = 2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_PUSH  = 6'b001000,
        ST_FINAL = 6'b010000,
        ST_LAST  = 6'b100000
    } dpf_state_t;

endpackage

// File: src/dpf_if.sv
// ----------------------------------------------------------------------------
// dpf_if: valid/ready channels of distinct_prime_factors
// Number channel in, factor channel out; a transfer is valid and ready high.
// ----------------------------------------------------------------------------
interface dpf_num_if #(parameter int WIDTH = 31);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface dpf_fac_if #(parameter int WIDTH = 31);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] prime_factor;
    logic             factor_valid;
    logic             input_error;
    logic             last_factor;

    modport source (output valid, output prime_factor, output factor_valid,
                    output input_error, output last_factor, input ready);
    modport sink   (input valid, input prime_factor, input factor_valid,
                    input input_error, input last_factor, output ready);
endinterface

// File: src/dpf_divider.sv
// ----------------------------------------------------------------------------
// dpf_divider: iterative restoring divider
// One quotient bit per cycle; done pulses with quotient and remainder.
// ----------------------------------------------------------------------------
module dpf_divider #(
    parameter int WIDTH = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH + 1);
    localparam logic [CW-1:0] STEPS = CW'(WIDTH);
    localparam logic [CW-1:0] ONE   = CW'(1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH:0]   rem_reg, rem_next;
    logic [WIDTH-1:0] div_reg, div_next;

    logic [WIDTH:0] shifted;
    logic [WIDTH:0] diff;
    logic           ge;

    assign shifted = {rem_reg[WIDTH-1:0], quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = shifted >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEPS;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff : shifted;
            quo_next = {quo_reg[WIDTH-2:0], ge};
            cnt_next = cnt_reg - ONE;
            if (cnt_reg == ONE)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[WIDTH-1:0];

endmodule

// File: src/distinct_prime_factors.sv
// An input n needs about sqrt(n)/2 trial divisions in the shared divider, plus
// one per removed factor; inputs 0 and 1 do not use the divider.
// Throughput: one input at a time; the number channel is ready only when idle.
// Reset: rst_n clears the sequencer, the output valid and the pending factor.
// ----------------------------------------------------------------------------
// distinct_prime_factors: trial division prime factorization
// Emits up to RUN_LIMIT distinct prime factors of each number, ascending.
// ----------------------------------------------------------------------------
module distinct_prime_factors
    import dpf_pkg::*;
#(
    parameter int NUMBER_WIDTH = 31
) (
    input  logic clk,
    input  logic rst_n,
    dpf_num_if.sink   num_ch,
    dpf_fac_if.source fac_ch
);

    localparam int W = NUMBER_WIDTH;
    localparam logic [W-1:0] C_FIRST  = W'(CAND_FIRST);
    localparam logic [W-1:0] C_SECOND = W'(CAND_SECOND);
    localparam logic [W-1:0] C_STEP   = W'(CAND_STEP);
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    typedef struct packed {
        logic [W-1:0] factor;
        logic         valid;
        logic         error;
    } result_t;

    typedef struct packed {
        result_t res;
        logic    last;
    } out_t;

    dpf_state_t state_reg, state_next;
    logic       strip_reg, strip_next;
    logic       pend_valid_reg, pend_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [W-1:0] rest_reg, rest_next;
    logic [W-1:0] cand_reg, cand_next;
    result_t pend_reg, pend_next;
    out_t    out_reg, out_next;

    logic         slot_free;
    logic         div_start;
    logic         div_done;
    logic [W-1:0] quo;
    logic [W-1:0] rem;
    logic [W-1:0] cand_step;

    dpf_divider #(
        .WIDTH (W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rest_reg),
        .divisor   (cand_reg),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    assign slot_free = !out_valid_reg || fac_ch.ready;
    assign div_start = (state_reg == ST_DIV);
    assign cand_step = (cand_reg == C_FIRST) ? C_SECOND : cand_reg + C_STEP;

    always_comb
    begin
        state_next      = state_reg;
        strip_next      = strip_reg;
        pend_valid_next = pend_valid_reg;
        count_next      = count_reg;
        rest_next       = rest_reg;
        cand_next       = cand_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !fac_ch.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (num_ch.valid)
                begin
                    if (num_ch.number[W-1:1] == '0)
                    begin
                        pend_next  = '{factor: '0, valid: 1'b0, error: !num_ch.number[0]};
                        state_next = ST_LAST;
                    end
                    else
                    begin
                        rest_next       = num_ch.number;
                        cand_next       = C_FIRST;
                        count_next      = '0;
                        strip_next      = 1'b0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    if (strip_reg)
                    begin
                        if (rem == '0)
                        begin
                            rest_next = quo;
                        end
                        else
                        begin
                            cand_next  = cand_step;
                            strip_next = 1'b0;
                        end
                        state_next = ST_DIV;
                    end
                    else if (count_reg == RUN_LIMIT || cand_reg > quo)
                    begin
                        state_next = ST_FINAL;
                    end
                    else if (rem == '0)
                    begin
                        rest_next  = quo;
                        count_next = count_reg + CNT_ONE;
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        cand_next  = cand_step;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_PUSH:
            begin
                if (slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next       = '{res: pend_reg, last: 1'b0};
                        out_valid_next = 1'b1;
                    end
                    pend_next       = '{factor: cand_reg, valid: 1'b1, error: 1'b0};
                    pend_valid_next = 1'b1;
                    strip_next      = 1'b1;
                    state_next      = ST_DIV;
                end
            end
            ST_FINAL:
            begin
                if (slot_free)
                begin
                    if ((rest_reg[W-1:1] != '0) && (count_reg != RUN_LIMIT))
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = '{res: pend_reg, last: 1'b0};
                            out_valid_next = 1'b1;
                        end
                        pend_next       = '{factor: rest_reg, valid: 1'b1, error: 1'b0};
                        pend_valid_next = 1'b1;
                    end
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (slot_free)
                begin
                    out_next        = '{res: pend_reg, last: 1'b1};
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            strip_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            strip_reg      <= strip_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        cand_reg <= cand_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign num_ch.ready        = (state_reg == ST_IDLE);
    assign fac_ch.valid        = out_valid_reg;
    assign fac_ch.prime_factor = out_reg.res.factor;
    assign fac_ch.factor_valid = out_reg.res.valid;
    assign fac_ch.input_error  = out_reg.res.error;
    assign fac_ch.last_factor  = out_reg.last;

endmodule
